>>> rtl/core/egc_pkg.sv
// shared types, codes and constants of the grip controller
`default_nettype none

package egc_pkg;

    // fixed field widths
    localparam int LEVEL_W  = 10;
    localparam int ANGLE_W  = 8;
    localparam int MODE_W   = 2;
    localparam int ALPHA_W  = 8;
    localparam int COUNT_W  = 16;
    localparam int OFFSET_W = 10;

    // filter gain is in 1/256 units
    localparam int ALPHA_FRAC = 8;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam logic [1:0] REG_ALPHA  = 2'd0;
    localparam logic [1:0] REG_CALIB  = 2'd1;
    localparam logic [1:0] REG_LOW    = 2'd2;
    localparam logic [1:0] REG_HIGH   = 2'd3;

    // register reset values
    localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 8'd26;
    localparam logic [COUNT_W-1:0]  CALIB_RST  = 16'd5000;
    localparam logic [OFFSET_W-1:0] LOW_RST    = 10'd10;
    localparam logic [OFFSET_W-1:0] HIGH_RST   = 10'd50;

    // grip modes
    localparam logic [MODE_W-1:0] MODE_CALIB   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REST    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PARTIAL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLOSED  = 2'd3;

    // rest pose
    localparam logic [ANGLE_W-1:0] REST_PINKY  = 8'd30;
    localparam logic [ANGLE_W-1:0] REST_RING   = 8'd20;
    localparam logic [ANGLE_W-1:0] REST_MIDDLE = 8'd160;
    localparam logic [ANGLE_W-1:0] REST_INDEX  = 8'd0;
    localparam logic [ANGLE_W-1:0] REST_THUMB  = 8'd90;

    // closed pose (thumb keeps its held angle)
    localparam logic [ANGLE_W-1:0] CLOSED_PINKY  = 8'd90;
    localparam logic [ANGLE_W-1:0] CLOSED_RING   = 8'd160;
    localparam logic [ANGLE_W-1:0] CLOSED_MIDDLE = 8'd50;
    localparam logic [ANGLE_W-1:0] CLOSED_INDEX  = 8'd180;

    // proportional mapping: three distinct spans (60, 70, 90 degrees)
    localparam int LANES    = 3;
    localparam int LANE_60  = 0;
    localparam int LANE_70  = 1;
    localparam int LANE_90  = 2;
    localparam int GAIN_W   = 7;
    localparam int QUOT_W   = 7;
    localparam int NUM_W    = OFFSET_W + GAIN_W;

    // sample queue between filter and controller
    localparam int QUEUE_DEPTH = 2;

    function automatic logic [GAIN_W-1:0] lane_gain(input int lane);
        logic [GAIN_W-1:0] g;
        unique case (lane)
            LANE_60: g = 7'd60;
            LANE_70: g = 7'd70;
            default: g = 7'd90;
        endcase
        return g;
    endfunction

    typedef struct packed {
        logic                start;
        logic [OFFSET_W-1:0] delta;
        logic [OFFSET_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                         done;
        logic [LANES-1:0][QUOT_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [LEVEL_W-1:0] level;
        logic [ANGLE_W-1:0] pinky;
        logic [ANGLE_W-1:0] ring;
        logic [ANGLE_W-1:0] middle;
        logic [ANGLE_W-1:0] index;
        logic [ANGLE_W-1:0] thumb;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/egc_front.sv
// front end: takes samples and runs the exponential smoothing filter
`default_nettype none

module egc_front
    import egc_pkg::*;
#(
    parameter int SAMPLE_BITS   = 10,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [SAMPLE_BITS-1:0] emg_sample,
    input  wire logic [ALPHA_W-1:0]     alpha_q8,
    input  wire logic                   q_full,
    output logic                        q_push,
    output logic [SAMPLE_BITS-1:0]      q_level
);

    localparam int FW = SAMPLE_BITS + FRACTION_BITS;
    localparam int PW = FW + ALPHA_W + 2;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_UPD  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [SAMPLE_BITS-1:0] x_reg, x_next;
    logic [FW-1:0]          fl_reg, fl_next;
    logic signed [PW-1:0]   prod_reg, prod_next;

    logic signed [FW:0]     diff;
    logic signed [FW+1:0]   upd;

    // alpha * (sample - level), then level + that / 256 with floor
    always_comb
    begin
        diff = $signed({1'b0, x_reg, {FRACTION_BITS{1'b0}}}) - $signed({1'b0, fl_reg});
        upd  = $signed({2'b00, fl_reg}) + $signed(prod_reg[PW-1:ALPHA_FRAC]);
    end

    assign full    = (state_reg != F_IDLE);
    assign q_push  = (state_reg == F_UPD) && !q_full;
    assign q_level = upd[FW-1:FRACTION_BITS];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        fl_next    = fl_reg;
        prod_next  = prod_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    x_next     = emg_sample;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                prod_next  = $signed({1'b0, alpha_q8}) * diff;
                state_next = F_UPD;
            end
            F_UPD:
            begin
                if (!q_full)
                begin
                    fl_next    = upd[FW-1:0];
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            fl_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fl_reg    <= fl_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/egc_queue.sv
// short queue of smoothed levels between front and back
`default_nettype none

module egc_queue
    import egc_pkg::*;
#(
    parameter int WIDTH = 10,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  q_full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/egc_div.sv
// three-lane restoring divider for the proportional finger mapping
`default_nettype none

module egc_div
    import egc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int STEP_W = $clog2(QUOT_W);
    localparam logic [STEP_W-1:0] TOP_STEP = STEP_W'(QUOT_W - 1);

    logic                         busy_reg, done_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [OFFSET_W-1:0]          divisor_reg;
    logic [LANES-1:0][NUM_W-1:0]  rem_reg;
    logic [LANES-1:0][QUOT_W-1:0] quot_reg;

    logic [NUM_W-1:0]             shifted;
    logic [LANES-1:0][NUM_W:0]    trial;

    // one quotient bit per lane per cycle, most significant first
    always_comb
    begin
        shifted = NUM_W'(divisor_reg) << step_reg;
        for (int l = 0; l < LANES; l++)
        begin
            trial[l] = {1'b0, rem_reg[l]} - {1'b0, shifted};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= TOP_STEP;
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    // operands and partial results
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            divisor_reg <= req.divisor;
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[l]  <= NUM_W'(req.delta) * NUM_W'(lane_gain(l));
                quot_reg[l] <= '0;
            end
        end
        else if (busy_reg)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (!trial[l][NUM_W])
                begin
                    rem_reg[l]            <= trial[l][NUM_W-1:0];
                    quot_reg[l][step_reg] <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/egc_back.sv
// back end: calibration, grip decision, finger angles and result register
`default_nettype none

module egc_back
    import egc_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_empty,
    input  wire logic [SAMPLE_BITS-1:0] q_level,
    output logic                        q_pop,
    input  wire logic [COUNT_W-1:0]     calib_samples,
    input  wire logic [OFFSET_W-1:0]    low_offset,
    input  wire logic [OFFSET_W-1:0]    high_offset,
    output div_req_t                    div_req,
    input  wire div_rsp_t               div_rsp,
    input  wire logic                   pop,
    output logic                        empty,
    output result_t                     result
);

    localparam int DW = ((SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [SAMPLE_BITS-1:0] level_reg, level_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   calib_reg, calib_next;
    logic [LEVEL_W-1:0]     base_reg, base_next;
    logic [ANGLE_W-1:0]     hold_reg, hold_next;
    logic                   valid_reg, valid_next;
    result_t                work_reg, work_next;
    result_t                out_reg, out_next;

    logic signed [DW-1:0]   delta;
    logic                   out_free;

    assign delta = $signed(DW'(level_reg)) - $signed(DW'(base_reg));

    assign out_free = !valid_reg || pop;
    assign empty    = !valid_reg;
    assign result   = out_reg;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;

    assign div_req.start   = (state_reg == S_EVAL) && !calib_reg
                             && !(delta > $signed(DW'(high_offset)))
                             && (delta > $signed(DW'(low_offset)));
    assign div_req.delta   = delta[OFFSET_W-1:0];
    assign div_req.divisor = high_offset;

    // controller
    always_comb
    begin
        state_next = state_reg;
        level_next = level_reg;
        count_next = count_reg;
        calib_next = calib_reg;
        base_next  = base_reg;
        hold_next  = hold_reg;
        valid_next = valid_reg;
        work_next  = work_reg;
        out_next   = out_reg;

        if (pop && valid_reg)
        begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    level_next = q_level;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                work_next.level  = LEVEL_W'(level_reg);
                work_next.pinky  = REST_PINKY;
                work_next.ring   = REST_RING;
                work_next.middle = REST_MIDDLE;
                work_next.index  = REST_INDEX;
                work_next.thumb  = REST_THUMB;
                state_next       = S_DONE;
                if (calib_reg)
                begin
                    // calibration: rest pose, baseline latched at the end
                    work_next.mode  = MODE_CALIB;
                    work_next.thumb = hold_reg;
                    if (count_reg < calib_samples)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        calib_next = 1'b0;
                        base_next  = LEVEL_W'(level_reg);
                    end
                end
                else
                begin
                    priority if (delta > $signed(DW'(high_offset)))
                    begin
                        work_next.mode   = MODE_CLOSED;
                        work_next.pinky  = CLOSED_PINKY;
                        work_next.ring   = CLOSED_RING;
                        work_next.middle = CLOSED_MIDDLE;
                        work_next.index  = CLOSED_INDEX;
                        work_next.thumb  = hold_reg;
                    end
                    else if (delta > $signed(DW'(low_offset)))
                    begin
                        work_next.mode = MODE_PARTIAL;
                        state_next     = S_DIV;
                    end
                    else
                    begin
                        work_next.mode = MODE_REST;
                        hold_next      = REST_THUMB;
                    end
                end
            end
            S_DIV:
            begin
                // angles from the divider quotients
                if (div_rsp.done)
                begin
                    work_next.pinky  = REST_PINKY + ANGLE_W'(div_rsp.quot[LANE_60]);
                    work_next.ring   = REST_RING + ANGLE_W'(div_rsp.quot[LANE_70]);
                    work_next.middle = REST_MIDDLE - ANGLE_W'(div_rsp.quot[LANE_70]);
                    work_next.index  = REST_INDEX + ANGLE_W'(div_rsp.quot[LANE_90]);
                    work_next.thumb  = REST_THUMB + ANGLE_W'(div_rsp.quot[LANE_90]);
                    hold_next        = REST_THUMB + ANGLE_W'(div_rsp.quot[LANE_90]);
                    state_next       = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next   = work_reg;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            calib_reg <= 1'b1;
            base_reg  <= '0;
            hold_reg  <= REST_THUMB;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            calib_reg <= calib_next;
            base_reg  <= base_next;
            hold_reg  <= hold_next;
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        work_reg  <= work_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/emg_grip_controller.sv
// path: filter (multiply, update), level queue, controller (evaluate, divide if flexing, done)
// flow: the filter takes one sample at a time and stalls on a full queue; the controller takes
// one item at a time, waiting on the 7-step three-lane divider in the flexing band and on a
// free result register on the output; a two-deep level queue sits between filter and controller
// reset: asynchronous active-low; filter level zero, calibrating, thumb held at 90 degrees,
// registers back to their defaults, level queue and result register empty
`default_nettype none

module emg_grip_controller
    import egc_pkg::*;
#(
    parameter int SAMPLE_BITS   = 10,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // sample side
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [SAMPLE_BITS-1:0] emg_sample,
    // result side
    output logic                        empty,
    input  wire logic                   pop,
    output logic [MODE_W-1:0]           grip_mode,
    output logic [LEVEL_W-1:0]          smoothed_level,
    output logic [ANGLE_W-1:0]          pinky_angle,
    output logic [ANGLE_W-1:0]          ring_angle,
    output logic [ANGLE_W-1:0]          middle_angle,
    output logic [ANGLE_W-1:0]          index_angle,
    output logic [ANGLE_W-1:0]          thumb_angle,
    // configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    logic [ALPHA_W-1:0]     alpha_reg;
    logic [COUNT_W-1:0]     calib_reg;
    logic [OFFSET_W-1:0]    low_reg;
    logic [OFFSET_W-1:0]    high_reg;
    logic                   cfg_wr;
    logic [1:0]             reg_sel;

    logic                   q_full, q_empty, q_push, q_pop;
    logic [SAMPLE_BITS-1:0] q_wr_level, q_rd_level;
    div_req_t               div_req;
    div_rsp_t               div_rsp;
    result_t                result;

    // register file
    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RST;
            calib_reg <= CALIB_RST;
            low_reg   <= LOW_RST;
            high_reg  <= HIGH_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_ALPHA: alpha_reg <= pwdata[ALPHA_W-1:0];
                REG_CALIB: calib_reg <= pwdata[COUNT_W-1:0];
                REG_LOW:   low_reg   <= pwdata[OFFSET_W-1:0];
                REG_HIGH:  high_reg  <= pwdata[OFFSET_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ALPHA: prdata = APB_DATA_W'(alpha_reg);
            REG_CALIB: prdata = APB_DATA_W'(calib_reg);
            REG_LOW:   prdata = APB_DATA_W'(low_reg);
            REG_HIGH:  prdata = APB_DATA_W'(high_reg);
            default:   prdata = '0;
        endcase
    end

    // filter front end
    egc_front #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .emg_sample (emg_sample),
        .alpha_q8   (alpha_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_level    (q_wr_level)
    );

    // level queue
    egc_queue #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_level),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_level),
        .q_empty (q_empty)
    );

    // proportional mapping divider
    egc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // controller back end
    egc_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_level       (q_rd_level),
        .q_pop         (q_pop),
        .calib_samples (calib_reg),
        .low_offset    (low_reg),
        .high_offset   (high_reg),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .pop           (pop),
        .empty         (empty),
        .result        (result)
    );

    assign grip_mode      = result.mode;
    assign smoothed_level = result.level;
    assign pinky_angle    = result.pinky;
    assign ring_angle     = result.ring;
    assign middle_angle   = result.middle;
    assign index_angle    = result.index;
    assign thumb_angle    = result.thumb;

    // checks
    a_closed_pose: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && grip_mode == MODE_CLOSED) |->
            (index_angle == CLOSED_INDEX && pinky_angle == CLOSED_PINKY))
        else $error("closed item with wrong finger pose");

    a_partial_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && grip_mode == MODE_PARTIAL) |->
            (pinky_angle >= REST_PINKY && pinky_angle <= CLOSED_PINKY
             && thumb_angle >= REST_THUMB && middle_angle >= CLOSED_MIDDLE))
        else $error("flexing item with finger angle outside its span");

    a_calib_pose: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && grip_mode == MODE_CALIB) |->
            (index_angle == REST_INDEX && middle_angle == REST_MIDDLE))
        else $error("calibration item not in rest pose");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting item changed or dropped before it was taken");

endmodule

`default_nettype wire
